// ===== design/pee_pkg.sv =====
// shared types, constants and codes for the prefix expression evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package pee_pkg;

  // datapath and stack sizing
  localparam int DATA_W      = 32;
  localparam int DIGIT_W     = 4;
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // divider step counter
  localparam int DIV_CNT_W = $clog2(DATA_W + 1);

  typedef logic [DATA_W-1:0] word_t;

  // command codes
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_PUSH = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_DIVZERO   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_leftmost;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/pee_front.sv =====
// front end: classifies incoming characters into commands and queues them
// depends on pee_pkg
`default_nettype none

module pee_front
  import pee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  wire logic     q_pop
);

  cmd_t                 cls_cmd;
  logic                 keep;
  logic                 push;
  cmd_t                 q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  // classify one character
  always_comb begin
    cls_cmd.op    = OP_NOP;
    cls_cmd.digit = DIGIT_W'(in_data.char_code - CH_ZERO);
    cls_cmd.last  = in_data.is_leftmost;
    if (in_data.char_code >= CH_ZERO && in_data.char_code <= CH_NINE) begin
      cls_cmd.op = OP_PUSH;
    end else begin
      case (in_data.char_code)
        CH_PLUS:  cls_cmd.op = OP_ADD;
        CH_MINUS: cls_cmd.op = OP_SUB;
        CH_STAR:  cls_cmd.op = OP_MUL;
        CH_SLASH: cls_cmd.op = OP_DIV;
        default:  cls_cmd.op = OP_NOP;
      endcase
    end
  end

  // ignored characters that do not end the expression never enter the queue
  assign keep     = (cls_cmd.op != OP_NOP) || cls_cmd.last;
  assign in_stall = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall && keep;

  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/pee_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on pee_pkg
`default_nettype none

module pee_div
  import pee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 fix_r, fix_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  word_t                rem_r, rem_nxt;
  word_t                quo_r, quo_nxt;
  word_t                mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  word_t                q_r, q_nxt;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      trial;
  word_t                ma, mb;

  assign ma = req.dividend[DATA_W-1] ? '0 - req.dividend : req.dividend;
  assign mb = req.divisor[DATA_W-1]  ? '0 - req.divisor  : req.divisor;

  // restoring step on magnitudes
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign trial  = rem_sh - {1'b0, mb_r};

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mb_nxt   = mb_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_nxt = trial[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r - DIV_CNT_W'(1);
      if (step_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      // sign of the quotient applied in a cycle of its own
      q_nxt    = neg_r ? '0 - quo_r : quo_r;
      done_nxt = 1'b1;
    end else if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = DIV_CNT_W'(DATA_W);
      rem_nxt  = '0;
      quo_nxt  = ma;
      mb_nxt   = mb;
      neg_nxt  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

// ===== design/pee_back.sv =====
// back end: operand stack, arithmetic, sticky status and the result register
// depends on pee_pkg; drives the divider pee_div through div_req_t/div_rsp_t
`default_nettype none

module pee_back
  import pee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire cmd_t     q_cmd,
  output logic          q_pop,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       err_r, err_nxt;
  word_t            tos_r, tos_nxt;
  logic [2:0]       op_r, op_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  word_t            rd_data_r;
  word_t            stack_mem [STACK_DEPTH];
  logic             mem_we;
  logic             rd_en;
  logic [CNT_W-1:0] wr_idx;
  logic [CNT_W-1:0] rd_idx;
  logic [1:0]       done_state;

  // top of stack lives in tos_r; entries below it live in stack_mem
  assign wr_idx = cnt_r - CNT_W'(1);
  assign rd_idx = cnt_r - CNT_W'(2);
  assign done_state = last_r ? S_EMIT : S_IDLE;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tos_r;
    div_req.divisor  = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          op_nxt    = q_cmd.op;
          last_nxt  = q_cmd.last;
          state_nxt = q_cmd.last ? S_EMIT : S_IDLE;
          case (q_cmd.op)
            OP_PUSH: begin
              if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                mem_we  = (cnt_r != '0);
                tos_nxt = DATA_W'(q_cmd.digit);
                cnt_nxt = cnt_r + CNT_W'(1);
              end else if (err_r == ST_OK) begin
                err_nxt = ST_OVERFLOW;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (cnt_r < CNT_W'(2)) begin
                if (err_r == ST_OK) begin
                  err_nxt = ST_UNDERFLOW;
                end
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        // left operand is the top, right operand is the entry below it
        state_nxt = done_state;
        cnt_nxt   = cnt_r - CNT_W'(1);
        case (op_r)
          OP_ADD: tos_nxt = tos_r + rd_data_r;
          OP_SUB: tos_nxt = tos_r - rd_data_r;
          OP_MUL: tos_nxt = tos_r * rd_data_r;
          OP_DIV: begin
            if (rd_data_r == '0) begin
              tos_nxt = '0;
              if (err_r == ST_OK) begin
                err_nxt = ST_DIVZERO;
              end
            end else begin
              div_req.start = 1'b1;
              cnt_nxt       = cnt_r;
              state_nxt     = S_DIV;
            end
          end
          default: cnt_nxt = cnt_r;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_nxt   = div_rsp.quot;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = done_state;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = (cnt_r != '0) ? $signed(tos_r) : '0;
          if (err_r != ST_OK) begin
            out_data_nxt.status = err_r;
          end else if (cnt_r == '0) begin
            out_data_nxt.status = ST_UNDERFLOW;
          end else begin
            out_data_nxt.status = ST_OK;
          end
          cnt_nxt   = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r      <= tos_nxt;
    op_r       <= op_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_idx[PTR_W-1:0]] <= tos_r;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_idx[PTR_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || !out_stall))
      |=> (out_valid_r && cnt_r == '0 && err_r == ST_OK && state_r == S_IDLE))
    else $error("result emit did not clear the stack");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK && state_r != S_EMIT) |=> (err_r == $past(err_r)))
    else $error("sticky error replaced");

  a_op_has_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC || state_r == S_DIV) |-> (cnt_r >= CNT_W'(2)))
    else $error("operator executing with fewer than two operands");
`endif

endmodule

`default_nettype wire

// ===== design/prefix_expression_evaluator.sv =====
// prefix (polish notation) expression evaluator, top level
// depends on pee_pkg, pee_front, pee_div and pee_back
//
// usage:
//   characters of an expression come in on the in_ channel, rightmost first,
//   one request per accepted in_valid & !in_stall; in_data.is_leftmost marks
//   the leftmost character and closes the expression
//   a digit pushes its value, + - * / pop two values (top is the left operand)
//   and push the result, 32-bit wrapping arithmetic, division toward zero;
//   other characters are dropped by the front end
//   each closed expression gives one request on the out_ channel: the top of
//   the stack (0 when empty) and a sticky status (ok, underflow, divide by
//   zero, overflow); the stack and status are then cleared
// throughput: the front queues up to 4 commands and accepts one per cycle
//   while there is room; the back end runs one command at a time, a digit
//   from S_IDLE, + - * through S_EXEC and / through S_EXEC and S_DIV (32
//   divider steps plus setup and sign fix in the iterative divider)
// output: the result is registered in S_EMIT, after the closing character's
//   command has finished
// reset: rst_n low clears the queue, stack count, status and output valid
// stall: a result waits in the output register while out_stall is high; the
//   back end keeps going until it has the next result, then holds, and the
//   queue filling up raises in_stall
`default_nettype none

module prefix_expression_evaluator
  import pee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  // classified command queue between front and back
  logic     q_valid;
  cmd_t     q_cmd;
  logic     q_pop;

  // divider handshake
  div_req_t div_req;
  div_rsp_t div_rsp;

  pee_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // iterative divider, used only by the / command
  pee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for prefix_expression_evaluator: streams expression characters,
// predicts each result with its own operand stack and compares every output request
// depends on pee_pkg and prefix_expression_evaluator
`timescale 1ns / 1ps

module testbench;
  import pee_pkg::*;

  typedef logic [7:0] char_seq_t [$];

  // generous ceiling for the divides and the idle bursts on both sides
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 950;
  // cycles to keep watching after the last expected result
  localparam int DRAIN_CYCLES = 60;

  // own model of the evaluator: operand stack, sticky status and pending results
  class expr_scoreboard;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       depth;
    logic [1:0]        sticky_status;
    out_item_t         expected_results [$];
    int unsigned       mismatches;

    function new();
      depth         = 0;
      sticky_status = ST_OK;
      mismatches    = 0;
    endfunction

    // only the first error of an expression is kept
    function void record_error(logic [1:0] code);
      if (sticky_status == ST_OK) begin
        sticky_status = code;
      end
    endfunction

    // apply one accepted character; a flagged one closes the expression
    function void note_char(in_item_t item);
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] mag_l;
      logic [DATA_W-1:0] mag_r;
      logic [DATA_W-1:0] quot;
      out_item_t         want;
      if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE) begin
        if (depth < STACK_DEPTH) begin
          operands[depth] = DATA_W'(item.char_code - CH_ZERO);
          depth++;
        end else begin
          record_error(ST_OVERFLOW);
        end
      end else if (item.char_code == CH_PLUS || item.char_code == CH_MINUS ||
                   item.char_code == CH_STAR || item.char_code == CH_SLASH) begin
        if (depth < 2) begin
          record_error(ST_UNDERFLOW);
        end else begin
          // top of stack is the left operand
          lhs = operands[depth-1];
          rhs = operands[depth-2];
          depth -= 2;
          case (item.char_code)
            CH_PLUS:  res = lhs + rhs;
            CH_MINUS: res = lhs - rhs;
            CH_STAR:  res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                record_error(ST_DIVZERO);
                res = '0;
              end else begin
                // divide magnitudes, fix the sign; min / -1 wraps back to min
                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                quot  = mag_l / mag_r;
                res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quot : quot;
              end
            end
          endcase
          operands[depth] = res;
          depth++;
        end
      end
      if (item.is_leftmost) begin
        want.value = (depth != 0) ? operands[depth-1] : '0;
        if (sticky_status != ST_OK) begin
          want.status = sticky_status;
        end else if (depth == 0) begin
          want.status = ST_UNDERFLOW;
        end else begin
          want.status = ST_OK;
        end
        expected_results.push_back(want);
        depth         = 0;
        sticky_status = ST_OK;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: value %0d status %0d", got.value, got.status);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.value, want.status, got.value, got.status);
          end
        end
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  expr_scoreboard sb = new();

  // idle bursts on both sides only while this is set
  bit          idle_enable = 1'b1;
  int unsigned sent_items  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;

  // ignored characters are spaces, letters and every other code
  string charset = "0123456789+-*/ ";
  logic [7:0] op_chars [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_STAR};

  // directed expressions, written leftmost first as a person would type them
  string directed_exprs [] = '{
    "0",                            // smallest digit alone
    "9",                            // largest digit alone
    "+ 3 4",                        // spaces dropped
    "-34",                          // top of stack is the left operand
    "*99",
    "/-072",                        // -7 / 2 truncates toward zero
    "/50",                          // divide by zero
    "+5",                           // operator short of operands
    " ",                            // nothing pushed at all
    "12",                           // two values left, top reported
    "/*8*8*8*8*8*8*8*8*8*82-01",    // 2^31 wraps to min, then min / -1
    "+/50",                         // divide by zero stays over a later underflow
    "99999999999999999"             // seventeen digits on a sixteen-deep stack
  };

  prefix_expression_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_active(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH;
  endfunction

  // one input request; an optional idle burst first so gaps land anywhere,
  // valid is lowered only at the step where it is not raised again
  task automatic send_char(input logic [7:0] c, input logic leftmost);
    in_item_t item;
    item.char_code = c;
    item.is_leftmost = leftmost;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // values read right after the edge are still the pre-edge ones
    do @(posedge clk); while (in_stall);
    sb.note_char(item);
    sent_items++;
  endtask

  // characters already in feed order; the last one is the leftmost
  task automatic send_feed(input char_seq_t feed);
    foreach (feed[i]) begin
      send_char(feed[i], i == feed.size() - 1);
    end
  endtask

  task automatic send_text(input string expr);
    char_seq_t feed;
    for (int i = expr.len() - 1; i >= 0; i--) begin
      feed.push_back(expr[i]);
    end
    send_feed(feed);
  endtask

  // result side: check on every accepted request, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    out_stall <= (stall_left != 0);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    char_seq_t   feed;
    logic [7:0]  filler;
    int unsigned random_start;
    int          kind;
    int          n_digits;
    int          pushed;
    int          level;

    // synchronous reset held low from the start, released once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_exprs[i]) begin
      send_text(directed_exprs[i]);
    end

    // random part: mostly well-formed expressions with random digits and
    // operators, some deeper than the stack, the rest arbitrary character runs
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      // idling on, then a quiet stretch, on again, and none at the tail
      idle_enable = (sent_items - random_start < 300) ||
                    (sent_items - random_start >= 450 &&
                     sent_items - random_start < 800);
      feed.delete();
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        if (kind == 14) begin
          n_digits = $urandom_range(17, 20);
        end else if ($urandom_range(0, 7) == 0) begin
          n_digits = $urandom_range(9, 16);
        end else begin
          n_digits = $urandom_range(1, 8);
        end
        pushed = 0;
        level  = 0;
        // build in feed order: an operator only when two operands are waiting
        while (pushed < n_digits || level > 1) begin
          if ($urandom_range(0, 9) == 0) begin
            do filler = 8'($urandom_range(0, 255)); while (is_active(filler));
            feed.push_back(filler);
          end
          if (level >= 2 && (pushed >= n_digits || $urandom_range(0, 1) == 1)) begin
            feed.push_back(op_chars[$urandom_range(0, 4)]);
            level--;
          end else begin
            feed.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            level++;
            pushed++;
          end
        end
        // sometimes a leading ignored character closes the expression
        if ($urandom_range(0, 7) == 0) begin
          do filler = 8'($urandom_range(0, 255)); while (is_active(filler));
          feed.push_back(filler);
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 2) == 0) begin
            feed.push_back(8'($urandom_range(0, 255)));
          end else begin
            feed.push_back(charset[$urandom_range(0, charset.len() - 1)]);
          end
        end
      end
      send_feed(feed);
    end

    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    // catch any stray request after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pee_pkg.sv
design/pee_front.sv
design/pee_div.sv
design/pee_back.sv
design/prefix_expression_evaluator.sv
bench/testbench.sv
